### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the house clock and reset names.
`define PAT_ASSERT_CR(lbl, prop, msg) \
  `PAT_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### sv/pat_pkg.sv
// Package: types, constants and helpers of the page access history tracker.
`default_nettype none

package pat_pkg;

  localparam int unsigned PageW          = 12;
  localparam int unsigned FreqW          = 4;
  localparam int unsigned CntW           = 32;
  localparam int unsigned HistBitsDef    = 8;
  localparam int unsigned PageEntriesDef = 4096;
  localparam logic [FreqW-1:0] FreqMax   = '1;

  typedef enum logic {
    ModeVisit     = 1'b0,
    ModeStartPass = 1'b1
  } mode_e;

  typedef enum logic {
    PhClear = 1'b0,
    PhRun   = 1'b1
  } phase_e;

  typedef struct packed {
    mode_e            mode;
    logic [PageW-1:0] page_number;
    logic             is_huge;
    logic             present;
    logic             trackable;
    logic             accessed;
  } in_item_t;

  typedef struct packed {
    logic [PageW-1:0] page_out;
    logic [FreqW-1:0] frequency;
    logic             freq_valid;
    logic [CntW-1:0]  total_base;
    logic [CntW-1:0]  idle_base;
    logic [CntW-1:0]  total_huge;
    logic [CntW-1:0]  idle_huge;
  } out_item_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + CntW'(1);
  endfunction

endpackage

`default_nettype wire

### sv/pat_stream_if.sv
// Valid/ready stream interface carrying one item per handshake.
`default_nettype none

interface pat_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/page_access_history_tracker_top.sv
// Top level: page access history table with pass counters.
// An accepted item waits in s1 while its history entry is read, then moves into the output register behind out_o.
// Throughput: one item per cycle while out_o is not stalled; the history RAM read, update and write-back take one pass.
// Reset: counters clear at once; then the history RAM is swept to zero, one entry per
//   cycle, over all PAGE_ENTRIES entries (4096 by default), with in_i.ready held low meanwhile.
// Same-page items back to back are served by forwarding the last written entry.
`default_nettype none

module page_access_history_tracker_top #(
  parameter int unsigned HISTORY_BITS = pat_pkg::HistBitsDef,
  parameter int unsigned PAGE_ENTRIES = pat_pkg::PageEntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pat_stream_if.sink    in_i,
  pat_stream_if.source  out_o
);
  import pat_pkg::*;

  localparam int unsigned AW = $clog2(PAGE_ENTRIES);
  // compare width: covers both the page field and the table index
  localparam int unsigned CW = ((AW > PageW) ? AW : PageW) + 1;
  // popcount width, padded so the saturation compare against FreqMax is clean
  localparam int unsigned PW = $clog2(HISTORY_BITS + 1) + FreqW;

  // ---------------------------------------------------------------- control
  phase_e phase_q, phase_d;
  logic [AW-1:0] clr_addr_q;
  logic          clr_last;

  logic     s1_vld_q;
  in_item_t s1_item_q;
  logic     s1_inrange_q;
  logic [AW-1:0] s1_addr_q;

  logic out_vld_q;
  logic out_free, s1_go, in_ready, in_acc;

  // ------------------------------------------------------------------ RAM
  logic [HISTORY_BITS-1:0] mem [PAGE_ENTRIES];
  logic [HISTORY_BITS-1:0] rd_data_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [HISTORY_BITS-1:0] mem_wd;

  // last write, for read-after-write on consecutive items
  logic                    wr_vld_q;
  logic [AW-1:0]           wr_addr_q;
  logic [HISTORY_BITS-1:0] wr_data_q;

  // ------------------------------------------------------------- datapath
  logic [CW-1:0]           page_ext;
  logic [AW-1:0]           in_addr;
  logic                    in_range;
  logic [HISTORY_BITS-1:0] hist_old, hist_new;
  logic                    visit, track;
  logic [PW-1:0]           ones;
  logic [FreqW-1:0]        freq;

  logic [CntW-1:0] cnt_tb_q, cnt_ib_q, cnt_th_q, cnt_ih_q;
  logic [CntW-1:0] cnt_tb_d, cnt_ib_d, cnt_th_d, cnt_ih_d;

  logic [PageW-1:0] out_page_q;
  logic [FreqW-1:0] out_freq_q;
  logic             out_fv_q;

  // ---------------------------------------------------------- phase FSM
  assign clr_last = (clr_addr_q == AW'(PAGE_ENTRIES - 1));

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhClear: if (clr_last) phase_d = PhRun;
      PhRun:   phase_d = PhRun;
      default: phase_d = PhClear;
    endcase
  end

  // Item flow: s1 holds the item whose RAM read is in flight; it retires
  // into the output register when that register is free or being drained.
  always_comb begin
    out_free = !out_vld_q || out_o.ready;
    s1_go    = s1_vld_q && out_free;
    in_ready = 1'b0;
    case (phase_q)
      PhClear: in_ready = 1'b0;
      PhRun:   in_ready = !s1_vld_q || out_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  // Pages beyond the table are treated as not trackable.
  assign page_ext = CW'(in_i.data.page_number);
  assign in_addr  = page_ext[AW-1:0];
  assign in_range = (page_ext < CW'(PAGE_ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhClear;
      clr_addr_q <= '0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      wr_vld_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (phase_q == PhClear) clr_addr_q <= clr_addr_q + AW'(1);
      if (in_acc)      s1_vld_q <= 1'b1;
      else if (s1_go)  s1_vld_q <= 1'b0;
      if (s1_go)             out_vld_q <= 1'b1;
      else if (out_o.ready)  out_vld_q <= 1'b0;
      if (s1_go && track)    wr_vld_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q    <= in_i.data;
      s1_inrange_q <= in_range;
      s1_addr_q    <= in_addr;
    end
    if (s1_go && track) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= hist_new;
    end
  end

  // Simple dual-port style RAM: one write (sweep or write-back), one registered read.
  always_comb begin
    if (phase_q == PhClear) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
    end else begin
      mem_we = s1_go && track;
      mem_wa = s1_addr_q;
      mem_wd = hist_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (in_acc) rd_data_q <= mem[in_addr];
  end

  // ------------------------------------------------------ history update
  assign hist_old = (wr_vld_q && (wr_addr_q == s1_addr_q)) ? wr_data_q : rd_data_q;
  assign hist_new = {s1_item_q.accessed, hist_old[HISTORY_BITS-1:1]};

  assign visit = (s1_item_q.mode == ModeVisit) && s1_item_q.present;
  assign track = visit && s1_item_q.trackable && s1_inrange_q;

  always_comb begin
    ones = '0;
    for (int i = 0; i < HISTORY_BITS; i++) begin
      ones = ones + PW'(hist_new[i]);
    end
    freq = (ones > PW'(FreqMax)) ? FreqMax : ones[FreqW-1:0];
  end

  // -------------------------------------------------------------- counters
  always_comb begin
    cnt_tb_d = cnt_tb_q;
    cnt_ib_d = cnt_ib_q;
    cnt_th_d = cnt_th_q;
    cnt_ih_d = cnt_ih_q;
    if (s1_item_q.mode == ModeStartPass) begin
      cnt_tb_d = '0;
      cnt_ib_d = '0;
      cnt_th_d = '0;
      cnt_ih_d = '0;
    end else if (visit) begin
      if (s1_item_q.is_huge) cnt_th_d = sat_inc(cnt_th_q);
      else                   cnt_tb_d = sat_inc(cnt_tb_q);
      if (track && !s1_item_q.accessed) begin
        if (s1_item_q.is_huge) cnt_ih_d = sat_inc(cnt_ih_q);
        else                   cnt_ib_d = sat_inc(cnt_ib_q);
      end
    end
  end

  // Counters move only when an item enters the output register, so they
  // double as the counter fields of the result on display.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_tb_q <= '0;
      cnt_ib_q <= '0;
      cnt_th_q <= '0;
      cnt_ih_q <= '0;
    end else if (s1_go) begin
      cnt_tb_q <= cnt_tb_d;
      cnt_ib_q <= cnt_ib_d;
      cnt_th_q <= cnt_th_d;
      cnt_ih_q <= cnt_ih_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_page_q <= s1_item_q.page_number;
      out_fv_q   <= track && s1_item_q.accessed;
      out_freq_q <= (track && s1_item_q.accessed) ? freq : '0;
    end
  end

  // ---------------------------------------------------------------- output
  assign out_o.valid           = out_vld_q;
  assign out_o.data.page_out   = out_page_q;
  assign out_o.data.frequency  = out_freq_q;
  assign out_o.data.freq_valid = out_fv_q;
  assign out_o.data.total_base = cnt_tb_q;
  assign out_o.data.idle_base  = cnt_ib_q;
  assign out_o.data.total_huge = cnt_th_q;
  assign out_o.data.idle_huge  = cnt_ih_q;

endmodule

`default_nettype wire

### sv/pat_checker.sv
// Port-level checker for the page access history tracker, with its bind.
`default_nettype none

`include "assert_macros.svh"

module pat_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input pat_pkg::out_item_t out_data_i
);
  import pat_pkg::*;

  // a shown result stays until taken
  `PAT_ASSERT_CR(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")

  // no frequency without its valid flag
  `PAT_ASSERT_CR(a_freq_zero, out_valid_i && !out_data_i.freq_valid |-> out_data_i.frequency == '0, "stray frequency")

  // an accessed page always has its top history bit set
  `PAT_ASSERT_CR(a_freq_nonzero, out_valid_i && out_data_i.freq_valid |-> out_data_i.frequency != '0, "zero frequency")

  // idle pages are a subset of seen pages
  `PAT_ASSERT_CR(a_idle_le_total, out_valid_i |-> (out_data_i.idle_base <= out_data_i.total_base) && (out_data_i.idle_huge <= out_data_i.total_huge), "idle exceeds total")

endmodule

bind page_access_history_tracker_top pat_checker u_pat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
